FILE: hw/rtl/ppst_pkg.sv
package ppst_pkg;

  localparam int unsigned SlotCountDefault = 64;
  localparam logic [63:0] HashMulA = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] HashMulB = 64'h94d049bb133111eb;
  localparam logic [63:0] MsDivisor = 64'd1000000;

  // Division by one million is done as a pre-shift by 6 (the power of two
  // in 10^6) followed by a multiplication with the rounded-up reciprocal of
  // the odd part, 15625. The quotient is the product shifted right by 76.
  // The reciprocal error stays below 2^14 and the shifted dividend below
  // 2^58, so the quotient is exact over the whole 64-bit range.
  localparam int unsigned MsPreShift = 6;
  localparam int unsigned MsRecipShift = 76;
  localparam logic [63:0] MsOddDivisor = MsDivisor >> MsPreShift;
  localparam logic [63:0] MsRecip =
    64'(((77'd1 << MsRecipShift) + 77'(MsOddDivisor) - 77'd1) / 77'(MsOddDivisor));

  typedef struct packed {
    logic [63:0] now_time;
    logic [63:0] token_key;
    logic [63:0] interval;
    logic [63:0] jitter;
  } ppst_in_t;

  typedef struct packed {
    logic [63:0] tick_count;
    logic [44:0] elapsed_ms;
    logic [63:0] missed_ticks;
  } ppst_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_READ,
    ST_EVAL,
    ST_DIV,
    ST_MSDIV,
    ST_WRITE,
    ST_DONE
  } ppst_state_t;

endpackage

FILE: hw/rtl/periodic_pulse_slot_tracker_unit.sv
// Periodic pulse slot tracker.
//
// A request transaction on the in_ channel carries a time stamp, a token,
// a tick interval and a jitter tolerance. The block hashes the token with
// the splitmix64 finalizer, probes the slot table linearly from the hashed
// start slot for the token or a free slot, and updates that slot's tick
// count. One result transaction per request leaves on the out_ channel.
//
// Work is done one request at a time. The hash runs on a shared 64x16
// partial-product multiplier (two products, four passes each). Each
// probed slot takes a read step and then a compare step, and from 1 to
// SLOT_COUNT slots are probed. The tick division runs on a restoring
// divider, one quotient bit per cycle, and is skipped on a slot's first
// use. The millisecond value is a reciprocal multiplication, four passes
// on the shared multiplier.
//
// Reset clears the used flags of all slots at once; key, time and tick
// storage need no clearing. When the receiver stalls, the result is held
// in the output register and no new request is taken until it is accepted.
// SLOT_COUNT must be a power of two; the start slot is the low hash bits.
module periodic_pulse_slot_tracker_unit
  import ppst_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SlotCountDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ppst_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ppst_out_t out_data
);

  localparam int unsigned IdxW = $clog2(SLOT_COUNT);

  // Request and working registers.
  ppst_state_t state_r, state_nxt;
  ppst_in_t    req_r;
  logic [63:0] period_r;
  logic [63:0] hash_r;
  logic [2:0]  pass_r;      // partial product chunk
  logic        hstep_r;     // which multiply of the finalizer
  logic [63:0] acc_r;
  logic [80:0] ms_acc_r;    // reciprocal product, low bits retired per pass
  logic [IdxW-1:0] idx_r;
  logic [IdxW:0]   probes_r;
  logic [IdxW-1:0] start_r;
  logic            fresh_r;
  logic [63:0] elapsed_r;
  logic [63:0] ticks_r;
  logic [63:0] last_r;
  logic [63:0] key_rd_r;
  logic        used_rd_r;
  logic [63:0] advanced_r;
  // Restoring divider for the tick count.
  logic [63:0] dvd_r, quo_r, rem_r, dvs_r;
  logic [6:0]  dcnt_r;
  ppst_out_t   out_r;
  logic        out_valid_r;

  // Slot storage.
  logic [SLOT_COUNT-1:0] used_r;
  logic [63:0] key_mem   [SLOT_COUNT];
  logic [63:0] time_mem  [SLOT_COUNT];
  logic [63:0] ticks_mem [SLOT_COUNT];

  // Shared 64x16 partial product, used by the hash and the ms conversion.
  logic [63:0] mul_const;
  logic [15:0] mul_chunk;
  logic [79:0] mul_prod;
  logic [63:0] mul_pp;
  always_comb begin
    if (state_r == ST_MSDIV) begin
      mul_const = MsRecip;
      mul_chunk = 16'((elapsed_r >> MsPreShift) >> {pass_r[1:0], 4'b0000});
    end else begin
      mul_const = hstep_r ? HashMulB : HashMulA;
      mul_chunk = 16'(hash_r >> {pass_r[1:0], 4'b0000});
    end
    mul_prod = 80'(mul_chunk) * 80'(mul_const);
    mul_pp   = mul_prod[63:0] << {pass_r[1:0], 4'b0000};
  end

  // Restoring divider step.
  logic [64:0] rem_sh;
  logic        dfit;
  always_comb begin
    rem_sh = {rem_r, dvd_r[63]};
    dfit   = rem_sh >= {1'b0, dvs_r};
  end

  logic [63:0] tolerated;
  always_comb begin
    tolerated = period_r + req_r.jitter;
    if (tolerated < period_r) tolerated = '1;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid && !out_valid_r) state_nxt = ST_HASH;
      ST_HASH:  if (hstep_r && pass_r == 3'd3) state_nxt = ST_PROBE;
      ST_PROBE: state_nxt = ST_READ;
      ST_READ:  begin
        if (!used_rd_r || key_rd_r == req_r.token_key ||
            probes_r == (IdxW+1)'(SLOT_COUNT - 1)) state_nxt = ST_EVAL;
        else state_nxt = ST_PROBE;
      end
      ST_EVAL:  state_nxt = fresh_r ? ST_MSDIV : ST_DIV;
      ST_DIV:   if (dcnt_r == 7'd64) state_nxt = ST_MSDIV;
      ST_MSDIV: if (pass_r == 3'd3) state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready  = (state_r == ST_IDLE) && !out_valid_r;
    out_valid = out_valid_r;
    out_data  = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && !out_valid_r) begin
            req_r    <= in_data;
            period_r <= (in_data.interval == '0) ? 64'd1 : in_data.interval;
            hash_r   <= in_data.token_key ^ (in_data.token_key >> 30);
            acc_r    <= '0;
            pass_r   <= '0;
            hstep_r  <= 1'b0;
          end
        end
        ST_HASH: begin
          if (pass_r == 3'd3) begin
            pass_r <= '0;
            acc_r  <= '0;
            if (!hstep_r) begin
              hash_r  <= (acc_r + mul_pp) ^ ((acc_r + mul_pp) >> 27);
              hstep_r <= 1'b1;
            end else begin
              hash_r  <= (acc_r + mul_pp) ^ ((acc_r + mul_pp) >> 31);
              idx_r   <= IdxW'((acc_r + mul_pp) ^ ((acc_r + mul_pp) >> 31));
              start_r <= IdxW'((acc_r + mul_pp) ^ ((acc_r + mul_pp) >> 31));
              probes_r <= '0;
            end
          end else begin
            acc_r  <= acc_r + mul_pp;
            pass_r <= pass_r + 3'd1;
          end
        end
        ST_PROBE: begin
          used_rd_r <= used_r[idx_r];
          key_rd_r  <= key_mem[idx_r];
          last_r    <= time_mem[idx_r];
          ticks_r   <= ticks_mem[idx_r];
        end
        ST_READ: begin
          if (!used_rd_r) begin
            fresh_r <= 1'b1;
          end else if (key_rd_r == req_r.token_key) begin
            fresh_r <= 1'b0;
          end else if (probes_r == (IdxW+1)'(SLOT_COUNT - 1)) begin
            // Table full: share the start slot.
            fresh_r <= 1'b0;
            idx_r   <= start_r;
            last_r  <= time_mem[start_r];
            ticks_r <= ticks_mem[start_r];
          end else begin
            probes_r <= probes_r + (IdxW+1)'(1);
            idx_r    <= (idx_r == IdxW'(SLOT_COUNT - 1)) ? '0 : idx_r + IdxW'(1);
          end
        end
        ST_EVAL: begin
          dcnt_r   <= '0;
          rem_r    <= '0;
          quo_r    <= '0;
          pass_r   <= '0;
          ms_acc_r <= '0;
          if (fresh_r) begin
            elapsed_r  <= period_r;
            advanced_r <= 64'd1;
            ticks_r    <= '0;
          end else begin
            elapsed_r <= (req_r.now_time >= last_r) ? req_r.now_time - last_r : '0;
            dvd_r     <= (req_r.now_time >= last_r) ? req_r.now_time - last_r : '0;
            dvs_r     <= period_r;
          end
        end
        ST_DIV: begin
          if (dcnt_r == 7'd64) begin
            dcnt_r     <= '0;
            advanced_r <= quo_r;
          end else begin
            rem_r  <= dfit ? 64'(rem_sh - {1'b0, dvs_r}) : rem_sh[63:0];
            quo_r  <= {quo_r[62:0], dfit};
            dvd_r  <= {dvd_r[62:0], 1'b0};
            dcnt_r <= dcnt_r + 7'd1;
          end
        end
        ST_MSDIV: begin
          // Lowest chunk first; the 16 retired bits lie below the quotient.
          ms_acc_r <= 81'(ms_acc_r >> 16) + 81'(mul_prod);
          pass_r   <= (pass_r == 3'd3) ? 3'd0 : pass_r + 3'd1;
        end
        ST_WRITE: begin
          if (fresh_r) begin
            used_r[idx_r]    <= 1'b1;
            key_mem[idx_r]   <= req_r.token_key;
            time_mem[idx_r]  <= req_r.now_time;
            ticks_mem[idx_r] <= '0;
          end else if (advanced_r != '0) begin
            time_mem[idx_r]  <= req_r.now_time;
            ticks_mem[idx_r] <= ticks_r + advanced_r;
            ticks_r          <= ticks_r + advanced_r;
          end
        end
        ST_DONE: begin
          out_r.tick_count   <= ticks_r;
          out_r.elapsed_ms   <= ms_acc_r[MsRecipShift - 48 +: 45];
          out_r.missed_ticks <= (advanced_r > 64'd1 && elapsed_r > tolerated)
                                ? advanced_r - 64'd1 : '0;
          out_valid_r        <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Never accept while a result is pending.
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ready) else $error("accept with pending result");
  // A result appears only after the done step.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE) else $error("stray result");
  // Divider counter stays in range.
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> dcnt_r <= 7'd64)
    else $error("divider count overrun");
  // The slot count is a power of two.
  a_slot_count_pow2: assert property (@(posedge clk)
    (SLOT_COUNT & (SLOT_COUNT - 1)) == 0) else $error("slot count not a power of two");

endmodule
